### sv/srs_pkg.sv
// Shared constants and types for the sorted row insertion search unit.
package srs_pkg;

    localparam int ROWS       = 16;
    localparam int ROW_DEPTH  = 256;
    localparam int DATA_WIDTH = 32;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int POS_W  = $clog2(ROW_DEPTH);
    localparam int IDX_W  = $clog2(ROW_DEPTH + 1);
    localparam int ADDR_W = ROW_W + POS_W;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic CFG_PICK_LEFT  = 1'b0;
    localparam logic CFG_ROW_LENGTH = 1'b1;

    typedef enum logic
    {
        ST_IDLE,
        ST_SEARCH
    } srs_state_t;

    typedef struct packed
    {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } srs_mem_ctrl_t;

endpackage

### sv/sorted_row_insertion_search_unit.sv
// Top level: row table with binary-search insertion index lookup.
//
// Input channel (in_valid/in_ready): mode 0 loads value into the table at
// row/position in the transfer cycle and gives no result; mode 1 searches
// row for value and gives one insert_index on the output channel.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 selects the
// leftmost (1) or rightmost (0) insertion point, index 1 row_length
// (saturated to the row depth).
// A load does not leave the idle state; the unit is ready again at once.
// A query uses the single table read port and one compare per cycle: one
// probe per cycle, at most log2(n)+1 probes for n = row_length; in_ready
// stays low until the result is in the output register.
// The output register holds the result while out_ready is low; a load may
// still transfer meanwhile, a following query finishes its search and
// waits for the output register to empty.
// Reset clears control state, selects the leftmost insertion point and sets
// row_length = 256; table contents are undefined until loaded.
module sorted_row_insertion_search_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [3:0]                    row,
    input  logic [7:0]                    position,
    input  logic signed [31:0]            value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [8:0]                    insert_index,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [8:0]                    cfg_data
);
    import srs_pkg::*;

    srs_state_t              state_reg, state_next;
    logic                    pick_left_reg;
    logic [IDX_W-1:0]        row_length_reg;
    logic [IDX_W-1:0]        lo_reg, lo_next;
    logic [IDX_W-1:0]        hi_reg, hi_next;
    logic [POS_W-1:0]        mid_reg, mid_next;
    logic                    pend_reg, pend_next;
    logic [ROW_W-1:0]        row_reg;
    logic signed [DATA_WIDTH-1:0] key_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]        index_reg, index_next;

    logic [IDX_W-1:0]        n_sat;
    logic                    in_fire, query_fire, load_fire;
    logic                    slot_free, go_right, done;
    logic [IDX_W-1:0]        lo_eff, hi_eff;
    logic [IDX_W:0]          mid_sum;
    logic signed [DATA_WIDTH-1:0] rd_data;
    srs_mem_ctrl_t           mem_ctrl;

    assign n_sat      = (row_length_reg > IDX_W'(ROW_DEPTH)) ? IDX_W'(ROW_DEPTH) : row_length_reg;
    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign query_fire = in_fire && (mode == MODE_QUERY);
    assign load_fire  = in_fire && (mode == MODE_LOAD);
    assign slot_free  = !out_valid_reg || out_ready;
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign insert_index = index_reg;

    // probe result and next interval
    assign go_right = pick_left_reg ? (key_reg > rd_data) : (key_reg >= rd_data);
    assign lo_eff   = (pend_reg && go_right) ? (IDX_W'(mid_reg) + IDX_W'(1)) : lo_reg;
    assign hi_eff   = (pend_reg && !go_right) ? IDX_W'(mid_reg) : hi_reg;
    assign mid_sum  = {1'b0, lo_eff} + {1'b0, hi_eff};
    assign done     = !(lo_eff < hi_eff);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_fire)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (done && slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        pend_next      = 1'b0;
        index_next     = index_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_ctrl.wr_en   = load_fire;
        mem_ctrl.wr_addr = {row, position};
        mem_ctrl.rd_en   = 1'b0;
        mem_ctrl.rd_addr = {row_reg, mid_sum[POS_W:1]};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_fire)
                begin
                    lo_next = '0;
                    hi_next = n_sat;
                end
            end
            ST_SEARCH:
            begin
                lo_next = lo_eff;
                hi_next = hi_eff;
                if (!done)
                begin
                    mid_next       = mid_sum[POS_W:1];
                    pend_next      = 1'b1;
                    mem_ctrl.rd_en = 1'b1;
                end
                else if (slot_free)
                begin
                    index_next     = lo_eff;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            pick_left_reg  <= 1'b1;
            row_length_reg <= IDX_W'(256);
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PICK_LEFT:  pick_left_reg  <= cfg_data[0];
                    CFG_ROW_LENGTH: row_length_reg <= cfg_data;
                    default:        pick_left_reg  <= pick_left_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        index_reg <= index_next;
        if (query_fire)
        begin
            row_reg <= row;
            key_reg <= value[DATA_WIDTH-1:0];
        end
    end

    srs_table u_table
    (
        .clk     (clk),
        .ctrl    (mem_ctrl),
        .wr_data (value[DATA_WIDTH-1:0]),
        .rd_data (rd_data)
    );

`ifndef SYNTH
    a_interval_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH && !pend_reg) |-> (lo_reg <= hi_reg))
        else $error("search interval inverted");

    a_hi_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (hi_reg <= n_sat))
        else $error("search upper bound exceeds row length");

    a_result_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (index_reg <= n_sat))
        else $error("insert index exceeds row length");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctrl.wr_en && mem_ctrl.rd_en))
        else $error("table read and write in same cycle");

    a_probe_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SEARCH && $past(state_reg) == ST_SEARCH))
        else $error("probe pending outside search");
`endif

endmodule

### sv/srs_table.sv
// Row table storage: one write port, one registered read port.
module srs_table
(
    input  logic                          clk,
    input  srs_pkg::srs_mem_ctrl_t        ctrl,
    input  logic [srs_pkg::DATA_WIDTH-1:0] wr_data,
    output logic [srs_pkg::DATA_WIDTH-1:0] rd_data
);
    import srs_pkg::*;

    logic [DATA_WIDTH-1:0] mem [ROWS*ROW_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data <= mem[ctrl.rd_addr];
        end
    end

endmodule
